>>> hw/rtl/thc_pkg.sv
// Package for the temperature and humidity compensation block.
// Holds configuration register indexes, widths and fixed arithmetic constants.
// No dependencies.
package thc_pkg;

    localparam int DATA_W = 32;
    localparam int RAW_W  = 20;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_TEMP_COEFF_ONE      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TEMP_COEFF_TWO      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TEMP_COEFF_THREE    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HUM_COEFF_ONE       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_HUM_COEFF_TWO       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_HUM_COEFF_THREE     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_HUM_COEFF_FOUR_FIVE = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_HUM_COEFF_SIX       = 3'd7;

    localparam logic OP_TEMPERATURE = 1'b0;
    localparam logic OP_HUMIDITY    = 1'b1;

    localparam logic [DATA_W-1:0] K_ONE       = 32'd1;
    localparam logic [DATA_W-1:0] K_FIVE      = 32'd5;
    localparam logic [DATA_W-1:0] K_128       = 32'd128;
    localparam logic [DATA_W-1:0] K_8192      = 32'd8192;
    localparam logic [DATA_W-1:0] K_16384     = 32'd16384;
    localparam logic [DATA_W-1:0] K_32768     = 32'd32768;
    localparam logic [DATA_W-1:0] K_76800     = 32'd76800;
    localparam logic [DATA_W-1:0] K_2097152   = 32'd2097152;
    localparam logic [DATA_W-1:0] K_HUM_LIMIT = 32'd419430400;

endpackage

>>> hw/rtl/temp_humidity_compensation.sv
// Top level of the temperature and humidity compensation block.
// Uses thc_pkg for register indexes and constants; instantiates nothing.
//
// Each transfer on the slave side carries one raw sample and an opcode in
// tuser bit 0: zero compensates a 20-bit temperature and stores the fine
// temperature, one compensates a 16-bit humidity against the stored fine
// temperature. One result transfer follows per input. All arithmetic runs on
// a single shared unit that multiplies, adds and shifts once per cycle under
// a small sequencer. The block is ready again the cycle after the result is
// registered. The block takes no new item until the current one is finished;
// a finished result waits in the output register while the next item is
// taken, and a result that finds the output register still full waits until
// it drains. Calibration registers are written through the plain write port;
// the user must write them only while idle; the block does not enforce it.
module temp_humidity_compensation (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [19:0] raw_sample, [23:20] zero
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_value
    output logic [0:0]  m_tuser    // [0] result_kind
);

    typedef enum logic [4:0] {
        S_IDLE, S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6,
        S_H0, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7, S_H8, S_H9,
        S_H10, S_H11, S_H12, S_H13, S_H14, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        DST_A, DST_B, DST_D, DST_X
    } dst_t;

    state_t      state_reg, state_next;
    logic [15:0] t1_reg, t2_reg, t3_reg, h2_reg;
    logic [7:0]  h1_reg, h3_reg, h6_reg;
    logic [23:0] h45_reg;
    logic [31:0] fine_reg;
    logic [19:0] raw_reg;
    logic        kind_reg;
    logic [31:0] ra_reg, rb_reg, rd_reg, rx_reg;
    logic        m_tvalid_reg;
    logic [31:0] m_data_reg;
    logic        m_kind_reg;

    logic [31:0] op_a, op_b, op_c, prod, sum, unit_y;
    logic        op_sub, fine_we;
    logic [4:0]  op_sh;
    dst_t        dst;
    logic [31:0] t1_ext, t2_ext, t3_ext, h1_ext, h2_ext, h3_ext, h4_sh, h5_ext, h6_ext;
    logic [31:0] hum_clamped;

    assign t1_ext = {16'd0, t1_reg};
    assign t2_ext = {{16{t2_reg[15]}}, t2_reg};
    assign t3_ext = {{16{t3_reg[15]}}, t3_reg};
    assign h1_ext = {24'd0, h1_reg};
    assign h2_ext = {{16{h2_reg[15]}}, h2_reg};
    assign h3_ext = {24'd0, h3_reg};
    assign h4_sh  = {h45_reg[11:0], 20'd0};
    assign h5_ext = {20'd0, h45_reg[23:12]};
    assign h6_ext = {{24{h6_reg[7]}}, h6_reg};

    assign prod   = op_a * op_b;
    assign sum    = op_sub ? (prod - op_c) : (prod + op_c);
    assign unit_y = $unsigned($signed(sum) >>> op_sh);

    always_comb begin
        op_a = thc_pkg::K_ONE;
        op_b = thc_pkg::K_ONE;
        op_c = '0;
        op_sub = 1'b0;
        op_sh = 5'd0;
        dst = DST_A;
        fine_we = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser[0] == thc_pkg::OP_HUMIDITY) ? S_H0 : S_T0;
                end
            end
            S_T0: begin
                op_a = {15'd0, raw_reg[19:3]};
                op_c = {t1_ext[30:0], 1'b0};
                op_sub = 1'b1;
                state_next = S_T1;
            end
            S_T1: begin
                op_a = ra_reg; op_b = t2_ext; op_sh = 5'd11;
                state_next = S_T2;
            end
            S_T2: begin
                op_a = {16'd0, raw_reg[19:4]}; op_c = t1_ext; op_sub = 1'b1;
                dst = DST_B;
                state_next = S_T3;
            end
            S_T3: begin
                op_a = rb_reg; op_b = rb_reg; op_sh = 5'd12; dst = DST_B;
                state_next = S_T4;
            end
            S_T4: begin
                op_a = rb_reg; op_b = t3_ext; op_sh = 5'd14; dst = DST_B;
                state_next = S_T5;
            end
            S_T5: begin
                op_a = ra_reg; op_c = rb_reg; fine_we = 1'b1;
                state_next = S_T6;
            end
            S_T6: begin
                op_a = ra_reg; op_b = thc_pkg::K_FIVE; op_c = thc_pkg::K_128;
                op_sh = 5'd8;
                state_next = S_DONE;
            end
            S_H0: begin
                op_a = fine_reg; op_c = thc_pkg::K_76800; op_sub = 1'b1; dst = DST_X;
                state_next = S_H1;
            end
            S_H1: begin
                op_a = h5_ext; op_b = rx_reg; op_c = thc_pkg::K_16384; op_sub = 1'b1;
                state_next = S_H2;
            end
            S_H2: begin
                op_a = h4_sh; op_c = ra_reg;
                state_next = S_H3;
            end
            S_H3: begin
                op_a = {2'd0, raw_reg[15:0], 14'd0}; op_c = ra_reg; op_sub = 1'b1;
                op_sh = 5'd15;
                state_next = S_H4;
            end
            S_H4: begin
                op_a = rx_reg; op_b = h6_ext; op_sh = 5'd10; dst = DST_B;
                state_next = S_H5;
            end
            S_H5: begin
                op_a = rx_reg; op_b = h3_ext; op_sh = 5'd11; dst = DST_D;
                state_next = S_H6;
            end
            S_H6: begin
                op_a = rd_reg; op_c = thc_pkg::K_32768; dst = DST_D;
                state_next = S_H7;
            end
            S_H7: begin
                op_a = rb_reg; op_b = rd_reg; op_sh = 5'd10; dst = DST_B;
                state_next = S_H8;
            end
            S_H8: begin
                op_a = rb_reg; op_c = thc_pkg::K_2097152; dst = DST_B;
                state_next = S_H9;
            end
            S_H9: begin
                op_a = rb_reg; op_b = h2_ext; op_c = thc_pkg::K_8192; op_sh = 5'd14;
                dst = DST_B;
                state_next = S_H10;
            end
            S_H10: begin
                op_a = ra_reg; op_b = rb_reg;
                state_next = S_H11;
            end
            S_H11: begin
                op_a = ra_reg; op_sh = 5'd15; dst = DST_B;
                state_next = S_H12;
            end
            S_H12: begin
                op_a = rb_reg; op_b = rb_reg; op_sh = 5'd7; dst = DST_B;
                state_next = S_H13;
            end
            S_H13: begin
                op_a = rb_reg; op_b = h1_ext; op_sh = 5'd4; dst = DST_B;
                state_next = S_H14;
            end
            S_H14: begin
                op_a = ra_reg; op_c = rb_reg; op_sub = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (ra_reg[31]) begin
            hum_clamped = '0;
        end else if (ra_reg > thc_pkg::K_HUM_LIMIT) begin
            hum_clamped = thc_pkg::K_HUM_LIMIT;
        end else begin
            hum_clamped = ra_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
            h1_reg <= '0;
            h2_reg <= '0;
            h3_reg <= '0;
            h45_reg <= '0;
            h6_reg <= '0;
            fine_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    thc_pkg::REG_TEMP_COEFF_ONE:      t1_reg  <= cfg_wr_data[15:0];
                    thc_pkg::REG_TEMP_COEFF_TWO:      t2_reg  <= cfg_wr_data[15:0];
                    thc_pkg::REG_TEMP_COEFF_THREE:    t3_reg  <= cfg_wr_data[15:0];
                    thc_pkg::REG_HUM_COEFF_ONE:       h1_reg  <= cfg_wr_data[7:0];
                    thc_pkg::REG_HUM_COEFF_TWO:       h2_reg  <= cfg_wr_data[15:0];
                    thc_pkg::REG_HUM_COEFF_THREE:     h3_reg  <= cfg_wr_data[7:0];
                    thc_pkg::REG_HUM_COEFF_FOUR_FIVE: h45_reg <= cfg_wr_data;
                    thc_pkg::REG_HUM_COEFF_SIX:       h6_reg  <= cfg_wr_data[7:0];
                    default: ;
                endcase
            end
            if (fine_we) begin
                fine_reg <= unit_y;
            end
            if (state_reg == S_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (state_reg == S_IDLE && s_tvalid) begin
            raw_reg <= s_tdata[19:0];
            kind_reg <= s_tuser[0];
        end
        if (state_reg != S_IDLE && state_reg != S_DONE) begin
            case (dst)
                DST_A:   ra_reg <= unit_y;
                DST_B:   rb_reg <= unit_y;
                DST_D:   rd_reg <= unit_y;
                DST_X:   rx_reg <= unit_y;
                default: ra_reg <= unit_y;
            endcase
        end
        if (state_reg == S_DONE && (!m_tvalid_reg || m_tready)) begin
            m_kind_reg <= kind_reg;
            m_data_reg <= (kind_reg == thc_pkg::OP_HUMIDITY) ?
                          {12'd0, hum_clamped[31:12]} : ra_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;

endmodule

>>> bench/thc_checker.sv
// Checker for the temperature and humidity compensation block.
// Watches the configuration port and both stream channels, predicts every result and
// compares it with the transfer seen on the master side. Depends on thc_pkg.
module thc_checker
    import thc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // [19:0] raw_sample, [23:20] zero
    input  logic [0:0]  s_tuser,   // [0] opcode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] result_value
    input  logic [0:0]  m_tuser,   // [0] result_kind
    output int          mismatches,
    output int          pending,
    output int          checked
);

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
    } reading_t;

    reading_t    expected_readings[$];
    reading_t    oldest;
    reading_t    fresh;
    logic [15:0] t1;
    logic signed [15:0] t2, t3, h2;
    logic [7:0]  h1, h3;
    logic [11:0] h4, h5;
    logic signed [7:0] h6;
    int          fine_temp;
    int          raw_in;
    int          err_count;
    int          result_count;

    function automatic int temperature_fine(input int raw);
        int c1, c2, c3, d, v1, v2;
        c1 = t1;
        c2 = t2;
        c3 = t3;
        v1 = (((raw >>> 3) - (c1 <<< 1)) * c2) >>> 11;
        d  = (raw >>> 4) - c1;
        v2 = (((d * d) >>> 12) * c3) >>> 14;
        return v1 + v2;
    endfunction

    function automatic int humidity_percent(input int raw, input int fine);
        int c1, c2, c3, c4, c5, c6, x, p, q, r, s;
        c1 = h1;
        c2 = h2;
        c3 = h3;
        c4 = h4;
        c5 = h5;
        c6 = h6;
        x = fine - 76800;
        p = ((raw <<< 14) - (c4 <<< 20) - c5 * x + 16384) >>> 15;
        q = (x * c6) >>> 10;
        r = ((x * c3) >>> 11) + 32768;
        s = ((q * r) >>> 10) + 2097152;
        s = (s * c2 + 8192) >>> 14;
        x = p * s;
        q = x >>> 15;
        x = x - ((((q * q) >>> 7) * c1) >>> 4);
        if (x < 0) begin
            x = 0;
        end else if (x > 419430400) begin
            x = 419430400;
        end
        return x >>> 12;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_readings.delete();
            t1 = '0;
            t2 = '0;
            t3 = '0;
            h1 = '0;
            h2 = '0;
            h3 = '0;
            h4 = '0;
            h5 = '0;
            h6 = '0;
            fine_temp    = 0;
            err_count    = 0;
            result_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_TEMP_COEFF_ONE:      t1 = cfg_wr_data[15:0];
                    REG_TEMP_COEFF_TWO:      t2 = cfg_wr_data[15:0];
                    REG_TEMP_COEFF_THREE:    t3 = cfg_wr_data[15:0];
                    REG_HUM_COEFF_ONE:       h1 = cfg_wr_data[7:0];
                    REG_HUM_COEFF_TWO:       h2 = cfg_wr_data[15:0];
                    REG_HUM_COEFF_THREE:     h3 = cfg_wr_data[7:0];
                    REG_HUM_COEFF_FOUR_FIVE: begin
                        h4 = cfg_wr_data[11:0];
                        h5 = cfg_wr_data[23:12];
                    end
                    REG_HUM_COEFF_SIX:       h6 = cfg_wr_data[7:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                result_count++;
                if (expected_readings.size() == 0) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("%0t: unexpected result transfer kind %0d value %0d",
                                 $realtime, m_tuser[0], $signed(m_tdata));
                    end
                end else begin
                    oldest = expected_readings.pop_front();
                    if (m_tuser[0] !== oldest.kind || m_tdata !== oldest.value) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("%0t: mismatch, expected %0d/%0d, got %0d/%0d",
                                     $realtime, oldest.kind, $signed(oldest.value),
                                     m_tuser[0], $signed(m_tdata));
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                raw_in = int'(s_tdata[19:0]);
                fresh.kind = s_tuser[0];
                if (s_tuser[0] == OP_TEMPERATURE) begin
                    fine_temp   = temperature_fine(raw_in);
                    fresh.value = (fine_temp * 5 + 128) >>> 8;
                end else begin
                    fresh.value = humidity_percent(raw_in & 32'h0000FFFF, fine_temp);
                end
                expected_readings.push_back(fresh);
            end
        end
        mismatches <= err_count;
        pending    <= expected_readings.size();
        checked    <= result_count;
    end

endmodule

>>> bench/testbench.sv
// Top of the bench for the temperature and humidity compensation block.
// Drives calibration sets and raw samples under varying back-pressure and gives
// the verdict; thc_checker does the prediction. Depends on thc_pkg.
module testbench;
    import thc_pkg::*;

    typedef enum {
        SET_TYPICAL,
        SET_NEAR_TYPICAL,
        SET_MAXIMUM,
        SET_MINIMUM,
        SET_RANDOM
    } coeff_set_e;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [23:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    int          mismatches;
    int          pending;
    int          checked;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          temp_items;
    int          hum_items;
    int          coeff_sets;

    temp_humidity_compensation u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    thc_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .pending     (pending),
        .checked     (checked)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_sample(input logic op, input logic [19:0] raw);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, raw};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == OP_TEMPERATURE) begin
            temp_items++;
        end else begin
            hum_items++;
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic load_coeffs(input coeff_set_e kind);
        logic [23:0] v [8];
        case (kind)
            SET_TYPICAL: begin
                v[REG_TEMP_COEFF_ONE]      = 24'd27504;
                v[REG_TEMP_COEFF_TWO]      = 24'd26435;
                v[REG_TEMP_COEFF_THREE]    = {8'd0, 16'hFC18};
                v[REG_HUM_COEFF_ONE]       = 24'd75;
                v[REG_HUM_COEFF_TWO]       = 24'd362;
                v[REG_HUM_COEFF_THREE]     = 24'd0;
                v[REG_HUM_COEFF_FOUR_FIVE] = {12'd50, 12'd313};
                v[REG_HUM_COEFF_SIX]       = 24'd30;
            end
            SET_NEAR_TYPICAL: begin
                v[REG_TEMP_COEFF_ONE]      = 24'($urandom_range(26000, 30000));
                v[REG_TEMP_COEFF_TWO]      = 24'($urandom_range(24000, 28000));
                v[REG_TEMP_COEFF_THREE]    = {8'd0, 16'(-int'($urandom_range(0, 2000)))};
                v[REG_HUM_COEFF_ONE]       = 24'($urandom_range(0, 100));
                v[REG_HUM_COEFF_TWO]       = 24'($urandom_range(300, 400));
                v[REG_HUM_COEFF_THREE]     = 24'($urandom_range(0, 10));
                v[REG_HUM_COEFF_FOUR_FIVE] = {12'($urandom_range(0, 60)),
                                              12'($urandom_range(250, 400))};
                v[REG_HUM_COEFF_SIX]       = 24'($urandom_range(0, 40));
            end
            SET_MAXIMUM: begin
                v[REG_TEMP_COEFF_ONE]      = 24'h00FFFF;
                v[REG_TEMP_COEFF_TWO]      = 24'h007FFF;
                v[REG_TEMP_COEFF_THREE]    = 24'h007FFF;
                v[REG_HUM_COEFF_ONE]       = 24'h0000FF;
                v[REG_HUM_COEFF_TWO]       = 24'h007FFF;
                v[REG_HUM_COEFF_THREE]     = 24'h0000FF;
                v[REG_HUM_COEFF_FOUR_FIVE] = 24'hFFFFFF;
                v[REG_HUM_COEFF_SIX]       = 24'h00007F;
            end
            SET_MINIMUM: begin
                v[REG_TEMP_COEFF_ONE]      = 24'h000000;
                v[REG_TEMP_COEFF_TWO]      = 24'h008000;
                v[REG_TEMP_COEFF_THREE]    = 24'h008000;
                v[REG_HUM_COEFF_ONE]       = 24'h000000;
                v[REG_HUM_COEFF_TWO]       = 24'h008000;
                v[REG_HUM_COEFF_THREE]     = 24'h000000;
                v[REG_HUM_COEFF_FOUR_FIVE] = 24'h000000;
                v[REG_HUM_COEFF_SIX]       = 24'h000080;
            end
            default: begin
                for (int i = 0; i < 8; i++) begin
                    v[i] = 24'($urandom);
                end
            end
        endcase
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_addr    <= 3'(i);
            cfg_wr_data <= v[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        coeff_sets++;
    endtask

    task automatic send_random_sample();
        logic        op;
        logic [19:0] raw;
        op = 1'($urandom_range(1));
        if (op == OP_TEMPERATURE && $urandom_range(9) < 7) begin
            raw = 20'($urandom_range(300000, 700000));
        end else begin
            raw = 20'($urandom);
        end
        send_sample(op, raw);
    endtask

    initial begin
        coeff_set_e phase_sets [6];
        phase_sets = '{SET_MAXIMUM, SET_MINIMUM, SET_NEAR_TYPICAL,
                       SET_RANDOM, SET_NEAR_TYPICAL, SET_RANDOM};
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = '0;
        cfg_wr_data   = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        m_tready      = 1'b0;
        send_idle_pct = 9;
        recv_idle_pct = 60;
        temp_items    = 0;
        hum_items     = 0;
        coeff_sets    = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Humidity before any temperature uses the cleared fine temperature.
        send_sample(OP_HUMIDITY, 20'hFFFFF);
        send_sample(OP_TEMPERATURE, 20'h7A120);
        send_sample(OP_HUMIDITY, 20'h08000);
        wait_drained();

        load_coeffs(SET_TYPICAL);
        send_sample(OP_HUMIDITY, 20'h06A00);
        send_sample(OP_TEMPERATURE, 20'h00000);
        send_sample(OP_HUMIDITY, 20'h00000);
        send_sample(OP_HUMIDITY, 20'h0FFFF);
        send_sample(OP_TEMPERATURE, 20'hFFFFF);
        send_sample(OP_HUMIDITY, 20'h06A00);
        send_sample(OP_TEMPERATURE, 20'h7EED0);
        send_sample(OP_HUMIDITY, 20'h06A00);
        // Upper sample bits must not matter for humidity.
        send_sample(OP_HUMIDITY, 20'hF6A00);
        send_sample(OP_HUMIDITY, 20'hFFFFF);
        send_sample(OP_TEMPERATURE, 20'h80000);
        send_sample(OP_TEMPERATURE, 20'hAAAAA);
        send_sample(OP_HUMIDITY, 20'h05555);
        send_sample(OP_TEMPERATURE, 20'h55555);
        send_sample(OP_HUMIDITY, 20'hAAAAA);
        send_sample(OP_HUMIDITY, 20'h08000);
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            load_coeffs(phase_sets[phase]);
            for (int i = 0; i < 190; i++) begin
                if (temp_items + hum_items < 400) begin
                    send_idle_pct = 9;
                    recv_idle_pct = 60;
                end else if (temp_items + hum_items < 800) begin
                    send_idle_pct = 60;
                    recv_idle_pct = 9;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                send_random_sample();
            end
            wait_drained();
        end

        repeat (40) @(posedge aclk);
        $display("Covered %0d temperature and %0d humidity samples over %0d calibration sets.",
                 temp_items, hum_items, coeff_sets);
        $display("Checked %0d result transfers, %0d mismatched.", checked, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("PASS temp_humidity_compensation");
        end else begin
            $display("FAIL temp_humidity_compensation");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("FAIL temp_humidity_compensation");
        $finish;
    end

endmodule
